>>> src/cycloid_foot_trajectory_top_assert.svh
// Assertion macros for the cycloid foot trajectory block.
// The clock is aclk and the reset aresetn in every module that uses them.
`ifndef CYCLOID_FOOT_TRAJECTORY_TOP_ASSERT_SVH
`define CYCLOID_FOOT_TRAJECTORY_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CFT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CFT_ASSERT(label, prop, msg)
`define CFT_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> src/cft_pkg.sv
// ----------------------------------------------------------------------------
// Cycloid foot trajectory package
// Register indexes, fixed-point constants and pipeline payload types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cft_pkg;

    typedef enum logic [2:0] {
        REG_DUTY          = 3'd0,
        REG_HALF_STEP     = 3'd1,
        REG_HIND_OFFSET   = 3'd2,
        REG_SWING_HEIGHTS = 3'd3,
        REG_NEUTRAL0      = 3'd4,
        REG_NEUTRAL1      = 3'd5,
        REG_NEUTRAL2      = 3'd6,
        REG_NEUTRAL3      = 3'd7
    } cfg_index_t;

    localparam int DIV_STEPS = 16;
    localparam logic [16:0] SUB_ONE   = 17'h10000;
    localparam logic [16:0] SUB_HALF  = 17'h08000;
    localparam logic [16:0] SIN_C0    = 17'd42048;
    localparam logic [16:0] SIN_C1    = 17'd4640;
    localparam logic [16:0] SIN_C2    = 17'd102944;
    localparam logic [13:0] INV_2PI   = 14'd10430;
    localparam logic [31:0] RND_HALF  = 32'd32768;
    localparam logic [15:0] DUTY_RST  = 16'd49152;

    // One stage of the restoring divider.
    typedef struct packed {
        logic [1:0]  leg;
        logic        stance;
        logic        sat;
        logic        zero;
        logic [16:0] rem;
        logic [16:0] den;
        logic [15:0] quo;
    } div_t;

    // Item context carried beside the trajectory arithmetic.
    typedef struct packed {
        logic [1:0]  leg;
        logic        stance;
        logic [16:0] sub;
    } ctx_t;

    function automatic div_t div_step(input div_t d);
        div_t        r;
        logic [17:0] twice;
        r     = d;
        twice = {d.rem, 1'b0};
        if (twice >= {1'b0, d.den}) begin
            r.rem = 17'(twice - {1'b0, d.den});
            r.quo = {d.quo[14:0], 1'b1};
        end else begin
            r.rem = twice[16:0];
            r.quo = {d.quo[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/cycloid_foot_trajectory_top.sv
// ----------------------------------------------------------------------------
// Cycloid foot trajectory generator
// Takes a leg, its gait phase and a stance flag and returns the foot target
// on a cycloid stance or swing path, with sub-phase and a done flag.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit up)                         tuser
//  s_        in         leg, gait_phase, zero pad                  in_stance
//  m_        out        leg_out, foot_x, foot_y, foot_z, sub_phase phase_done
//  cfg_      in         write enable, register index, 48-bit data  -
//
// One transaction is taken every cycle while the output is not held; each passes
// through 1 set-up stage, 16 divider stages (one quotient bit each), 8 stages
// of sine polynomial and scaling, and the output register.
// Reset is synchronous; it empties the pipeline and loads the register defaults.
// While the output waits, the whole pipeline holds and s_tready is low.
`timescale 1ns / 1ps
`default_nettype none
`include "cycloid_foot_trajectory_top_assert.svh"
module cycloid_foot_trajectory_top #(
    parameter int LEG_COUNT = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // leg[1:0], gait_phase[17:2], zero
    input  wire logic        s_tuser,   // in_stance
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // leg_out[1:0], foot_x[17:2], foot_y[33:18],
                                        // foot_z[49:34], sub_phase[66:50], zero
    output logic             m_tuser    // phase_done
);
    localparam int LEG_W = (LEG_COUNT > 2) ? 2 : 1;
    localparam int NS    = 8;  // stages A to H after the divider

    logic [15:0] duty_reg;
    logic [14:0] half_step_reg;
    logic [15:0] hind_offset_reg;
    logic [47:0] swing_heights_reg;
    logic [47:0] neutral_reg [LEG_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg          <= cft_pkg::DUTY_RST;
            half_step_reg     <= '0;
            hind_offset_reg   <= '0;
            swing_heights_reg <= '0;
            for (int i = 0; i < LEG_COUNT; i++) begin
                neutral_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                cft_pkg::REG_DUTY:          duty_reg          <= cfg_data[15:0];
                cft_pkg::REG_HALF_STEP:     half_step_reg     <= cfg_data[14:0];
                cft_pkg::REG_HIND_OFFSET:   hind_offset_reg   <= cfg_data[15:0];
                cft_pkg::REG_SWING_HEIGHTS: swing_heights_reg <= cfg_data;
                default: begin
                    for (int i = 0; i < LEG_COUNT; i++) begin
                        if (cfg_index == 3'(int'(cft_pkg::REG_NEUTRAL0) + i)) begin
                            neutral_reg[i] <= cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    logic en;
    logic acc;
    logic m_valid_reg;
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;
    assign m_tvalid = m_valid_reg;

    // Set-up: pick numerator and denominator of the sub-phase division.
    logic [15:0]  in_phase;
    logic         in_below;
    cft_pkg::div_t d0;
    assign in_phase = s_tdata[17:2];
    assign in_below = in_phase < duty_reg;
    always_comb begin
        d0.leg    = s_tdata[1:0];
        d0.stance = s_tuser;
        d0.sat    = s_tuser && ((duty_reg == '0) || !in_below);
        d0.zero   = !s_tuser && in_below;
        d0.rem    = s_tuser ? {1'b0, in_phase} : {1'b0, 16'(in_phase - duty_reg)};
        d0.den    = s_tuser ? {1'b0, duty_reg} : cft_pkg::SUB_ONE - {1'b0, duty_reg};
        d0.quo    = '0;
    end

    cft_pkg::div_t div_reg   [cft_pkg::DIV_STEPS+1];
    logic          div_v_reg [cft_pkg::DIV_STEPS+1];
    logic          v_reg     [NS];
    cft_pkg::ctx_t ctx_reg   [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= cft_pkg::DIV_STEPS; k++) begin
                div_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k < NS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            div_v_reg[0] <= acc;
            for (int k = 1; k <= cft_pkg::DIV_STEPS; k++) begin
                div_v_reg[k] <= div_v_reg[k-1];
            end
            v_reg[0] <= div_v_reg[cft_pkg::DIV_STEPS];
            for (int k = 1; k < NS; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Stage A context comes out of the divider; later stages pass it on.
    cft_pkg::div_t dl;
    assign dl = div_reg[cft_pkg::DIV_STEPS];
    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0] <= d0;
            for (int k = 1; k <= cft_pkg::DIV_STEPS; k++) begin
                div_reg[k] <= cft_pkg::div_step(div_reg[k-1]);
            end
            ctx_reg[0].leg    <= dl.leg;
            ctx_reg[0].stance <= dl.stance;
            ctx_reg[0].sub    <= dl.sat ? cft_pkg::SUB_ONE :
                                 (dl.zero ? 17'd0 : {1'b0, dl.quo});
            for (int k = 1; k < NS; k++) begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // Sine of sub (lane 0) and of twice sub (lane 1), quarter-wave folded.
    logic [15:0] u [2];
    logic [16:0] fx [2];
    assign u[0] = ctx_reg[0].sub[15:0];
    assign u[1] = {ctx_reg[0].sub[14:0], 1'b0};
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            fx[l] = u[l][14] ? cft_pkg::SUB_ONE - {1'b0, u[l][13:0], 2'b00}
                             : {1'b0, u[l][13:0], 2'b00};
        end
    end

    logic [16:0] x_b_reg [2], x_c_reg [2], x_d_reg [2];
    logic        n_b_reg [2], n_c_reg [2], n_d_reg [2], n_e_reg [2];
    logic [16:0] xsq_b_reg [2], xsq_c_reg [2];
    logic [16:0] t1_c_reg [2];
    logic [16:0] t2_d_reg [2];
    logic [16:0] s_e_reg [2];
    logic signed [15:0] sk_f_reg [2];

    logic [33:0] sq_p [2];
    logic [29:0] c1_p [2];
    logic [33:0] c2_p [2];
    logic [33:0] s_p  [2];
    logic [31:0] k_p  [2];
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sq_p[l] = fx[l] * fx[l];
            c1_p[l] = xsq_b_reg[l] * 13'(cft_pkg::SIN_C1);
            c2_p[l] = xsq_c_reg[l] * t1_c_reg[l];
            s_p[l]  = x_d_reg[l] * t2_d_reg[l];
            k_p[l]  = s_e_reg[l] * cft_pkg::INV_2PI + cft_pkg::RND_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                x_b_reg[l]   <= fx[l];
                n_b_reg[l]   <= u[l][15];
                xsq_b_reg[l] <= sq_p[l][32:16];
                x_c_reg[l]   <= x_b_reg[l];
                n_c_reg[l]   <= n_b_reg[l];
                xsq_c_reg[l] <= xsq_b_reg[l];
                t1_c_reg[l]  <= cft_pkg::SIN_C0 - {4'b0, c1_p[l][28:16]};
                x_d_reg[l]   <= x_c_reg[l];
                n_d_reg[l]   <= n_c_reg[l];
                t2_d_reg[l]  <= cft_pkg::SIN_C2 - c2_p[l][32:16];
                n_e_reg[l]   <= n_d_reg[l];
                s_e_reg[l]   <= s_p[l][32:16];
                sk_f_reg[l]  <= n_e_reg[l] ? -$signed({2'b00, k_p[l][29:16]})
                                           :  $signed({2'b00, k_p[l][29:16]});
            end
        end
    end

    // Stage G: cycloid and lift profile terms as sign and magnitude.
    logic signed [21:0] sub_s, two_s, sk0_s, sk1_s, c_s, g_s;
    assign sub_s = $signed({5'b0, ctx_reg[5].sub});
    assign two_s = $signed({4'b0, ctx_reg[5].sub, 1'b0});
    assign sk0_s = 22'(sk_f_reg[0]);
    assign sk1_s = 22'(sk_f_reg[1]);
    assign c_s   = sub_s - sk0_s;
    assign g_s   = (ctx_reg[5].sub < cft_pkg::SUB_HALF) ? two_s - sk1_s
                 : $signed(22'd131072) - two_s + sk1_s;

    logic        cn_g_reg, gn_g_reg;
    logic [16:0] cm_g_reg;
    logic [17:0] gm_g_reg;
    logic signed [21:0] c_abs, g_abs;
    assign c_abs = c_s[21] ? -c_s : c_s;
    assign g_abs = g_s[21] ? -g_s : g_s;

    // Stage H: scale by the stride and by the lift height.
    logic [33:0] xm_p;
    logic [30:0] zm_p;
    assign xm_p = {half_step_reg, 1'b0} * cm_g_reg + 34'(cft_pkg::RND_HALF);
    assign zm_p = swing_heights_reg[11:0] * gm_g_reg + 31'(cft_pkg::RND_HALF);

    logic signed [21:0] xt_h_reg, zt_h_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            cn_g_reg <= c_s[21];
            gn_g_reg <= g_s[21];
            cm_g_reg <= c_abs[16:0];
            gm_g_reg <= g_abs[17:0];
            xt_h_reg <= cn_g_reg ? -$signed({4'b0, xm_p[33:16]})
                                 :  $signed({4'b0, xm_p[33:16]});
            zt_h_reg <= gn_g_reg ? -$signed({7'b0, zm_p[30:16]})
                                 :  $signed({7'b0, zm_p[30:16]});
        end
    end

    // Output stage: add the midstance, offsets and saturate.
    cft_pkg::ctx_t   ch;
    logic [LEG_W-1:0] legc;
    logic [47:0]     nv;
    logic signed [21:0] mx, my, mz, a_s, hl, ho, xs, zs;
    logic [15:0]     x_sat, z_sat;
    assign ch   = ctx_reg[NS-1];
    assign legc = (32'(ch.leg) >= LEG_COUNT) ? LEG_W'(LEG_COUNT - 1) : ch.leg[LEG_W-1:0];
    assign nv   = neutral_reg[legc];
    assign mx   = 22'($signed(nv[15:0]));
    assign my   = 22'($signed(nv[31:16]));
    assign mz   = 22'($signed(nv[47:32]));
    assign a_s  = $signed({7'b0, half_step_reg});
    assign hl   = $signed({10'b0, swing_heights_reg[12*legc +: 12]});
    assign ho   = (32'(legc) > 1) ? 22'($signed(hind_offset_reg)) : 22'sd0;
    assign xs   = (ch.stance ? mx + a_s - xt_h_reg : mx - a_s + xt_h_reg) - ho;
    assign zs   = ch.stance ? mz : mz + hl + zt_h_reg;
    assign x_sat = (xs > 22'sd32767) ? 16'h7fff : ((xs < -22'sd32768) ? 16'h8000 : xs[15:0]);
    assign z_sat = (zs > 22'sd32767) ? 16'h7fff : ((zs < -22'sd32768) ? 16'h8000 : zs[15:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= {5'b0, ch.sub, z_sat, my[15:0], x_sat, ch.leg};
            m_tuser <= (ch.sub == cft_pkg::SUB_ONE);
        end
    end

    `CFT_ASSERT_RST(a_reset_empties, !aresetn |=> !m_tvalid, "output valid right after reset")
    `CFT_ASSERT(a_done_flag, m_tvalid |-> (m_tuser == (m_tdata[66:50] == cft_pkg::SUB_ONE)),
        "phase_done disagrees with sub_phase")
    `CFT_ASSERT(a_flags_exclusive, div_v_reg[0] |-> !(div_reg[0].sat && div_reg[0].zero),
        "sub-phase both saturated and cleared")
    `CFT_ASSERT(a_swing_below_one, (v_reg[0] && !ctx_reg[0].stance) |->
        (ctx_reg[0].sub < cft_pkg::SUB_ONE), "swing sub-phase reached one")

endmodule
`default_nettype wire

>>> bench/cft_checker.sv
// ----------------------------------------------------------------------------
// Cycloid foot trajectory checker
// Watches the configuration port and both stream channels, predicts each foot
// target from the current register settings and compares it with the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module cft_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic        m_tuser,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [1:0]  leg;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [16:0] sub;
        logic        done;
    } foot_t;

    logic [15:0] duty_r;
    logic [14:0] step_r;
    logic [15:0] hind_r;
    logic [47:0] heights_r;
    logic [47:0] mid_r [4];
    foot_t       targets [$];

    // Product divided by 65536, rounded half away from zero.
    function automatic longint round_q16(longint a, longint b);
        longint ma, mb, m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = (ma * mb + 32768) >>> 16;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint quarter_sine(longint x);
        longint x2, t;
        x2 = (x * x) >>> 16;
        t = 42048 - ((x2 * 4640) >>> 16);
        t = 102944 - ((x2 * t) >>> 16);
        return (x * t) >>> 16;
    endfunction

    function automatic longint scaled_sine(longint u);
        longint w, x, s;
        w = u & 16'hFFFF;
        x = (w & 14'h3FFF) << 2;
        s = ((w >> 14) & 1) ? quarter_sine(65536 - x) : quarter_sine(x);
        if ((w >> 15) & 1) s = -s;
        return round_q16(s, 10430);
    endfunction

    function automatic longint clamp16(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic foot_t foot_target(logic [1:0] leg_in, logic [15:0] phase,
                                          logic stance);
        foot_t      f;
        logic [1:0] leg;
        longint     mx, my, mz, a, h0, hl, sub, x, z, g;
        // All four legs are present, so the index is used as it comes.
        leg = leg_in;
        mx = $signed(mid_r[leg][15:0]);
        my = $signed(mid_r[leg][31:16]);
        mz = $signed(mid_r[leg][47:32]);
        a  = step_r;
        h0 = heights_r[11:0];
        hl = (heights_r >> (12 * leg)) & 12'hFFF;
        if (stance) begin
            if (duty_r == 0) sub = 65536;
            else sub = (longint'(phase) << 16) / duty_r;
            if (sub > 65536) sub = 65536;
            x = mx + a - round_q16(2 * a, sub - scaled_sine(sub));
            z = mz;
        end else begin
            if (phase < duty_r) sub = 0;
            else sub = (longint'(phase - duty_r) << 16) / (65536 - longint'(duty_r));
            if (sub > 65536) sub = 65536;
            x = mx - a + round_q16(2 * a, sub - scaled_sine(sub));
            if (sub < 32768) g = 2 * sub - scaled_sine(2 * sub);
            else g = 131072 - 2 * sub + scaled_sine(2 * sub);
            z = mz + hl + round_q16(h0, g);
        end
        if (leg > 1) x -= longint'($signed(hind_r));
        f.leg  = leg_in;
        f.x    = 16'(clamp16(x));
        f.y    = 16'(my);
        f.z    = 16'(clamp16(z));
        f.sub  = 17'(sub);
        f.done = (sub >= 65536);
        return f;
    endfunction

    always @(posedge aclk) begin
        foot_t want, got;
        if (!aresetn) begin
            duty_r    <= cft_pkg::DUTY_RST;
            step_r    <= '0;
            hind_r    <= '0;
            heights_r <= '0;
            for (int i = 0; i < 4; i++) mid_r[i] <= '0;
            targets.delete();
            errors <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cft_pkg::cfg_index_t'(cfg_index))
                    cft_pkg::REG_DUTY:          duty_r    <= cfg_data[15:0];
                    cft_pkg::REG_HALF_STEP:     step_r    <= cfg_data[14:0];
                    cft_pkg::REG_HIND_OFFSET:   hind_r    <= cfg_data[15:0];
                    cft_pkg::REG_SWING_HEIGHTS: heights_r <= cfg_data;
                    default:                    mid_r[cfg_index[1:0]] <= cfg_data;
                endcase
            end
            if (s_tvalid && s_tready)
                targets.push_back(foot_target(s_tdata[1:0], s_tdata[17:2], s_tuser));
            if (m_tvalid && m_tready) begin
                got = {m_tdata[1:0], m_tdata[17:2], m_tdata[33:18], m_tdata[49:34],
                       m_tdata[66:50], m_tuser};
                if (targets.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h",
                             $time, got);
                    errors <= errors + 1;
                end else begin
                    want = targets.pop_front();
                    if (want !== got) begin
                        $display("%0t: mismatch, expected leg %0d x %h y %h z %h sub %h done %b",
                                 $time, want.leg, want.x, want.y, want.z, want.sub, want.done);
                        $display("%0t:           actual   leg %0d x %h y %h z %h sub %h done %b",
                                 $time, got.leg, got.x, got.y, got.z, got.sub, got.done);
                        errors <= errors + 1;
                    end
                end
            end
        end
        pending <= targets.size();
    end
endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Cycloid foot trajectory testbench
// Drives directed and random foot requests over several register settings,
// with random gaps on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tuser;
    int          errors, pending;

    cycloid_foot_trajectory_top uut (.*);
    cft_checker checker_i (.*);

    initial forever #5 aclk = ~aclk;

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Result side holds m_tready low for a randomly drawn gap, which may be zero, before taking each transaction.
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = $urandom_range(0, 3);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // The enable stays high until the caller drops it after the last write.
    task automatic write_reg(cft_pkg::cfg_index_t idx, logic [47:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // The valid stays high after acceptance so that transactions can follow
    // back to back; it is dropped before the next edge whenever a gap is drawn.
    task automatic send_foot(logic [1:0] leg, logic [15:0] phase, logic stance);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, phase, leg};
        s_tuser  <= stance;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic random_setting(int kind);
        logic [15:0] duty;
        case (kind)
            0: duty = 16'd1;
            1: duty = 16'hFFFF;
            2: duty = 16'd0;
            default: duty = 16'($urandom_range(1, 65535));
        endcase
        write_reg(cft_pkg::REG_DUTY, 48'(duty));
        write_reg(cft_pkg::REG_HALF_STEP, kind == 1 ? 48'h7FFF : 48'(15'($urandom)));
        write_reg(cft_pkg::REG_HIND_OFFSET, kind == 0 ? 48'h8000 : 48'(16'($urandom)));
        write_reg(cft_pkg::REG_SWING_HEIGHTS, kind == 1 ? 48'hFFFF_FFFF_FFFF
                                                        : 48'({$urandom, $urandom}));
        for (int i = 0; i < 4; i++)
            write_reg(cft_pkg::cfg_index_t'(cft_pkg::REG_NEUTRAL0 + i),
                      kind == 1 ? 48'h7FFF_8000_7FFF : 48'({$urandom, $urandom}));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int items;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Reset defaults first, then directed extremes.
        for (int l = 0; l < 4; l++) begin
            send_foot(2'(l), 16'd0, 1'b1);
            send_foot(2'(l), 16'hFFFF, 1'b0);
        end
        drain();
        random_setting(1);
        send_foot(2'd3, 16'hFFFF, 1'b1);
        send_foot(2'd2, 16'h0000, 1'b0);
        send_foot(2'd1, 16'hFFFE, 1'b0);
        send_foot(2'd0, 16'h8000, 1'b1);
        drain();
        // Zero duty sends the stance sub-phase straight to done.
        random_setting(2);
        send_foot(2'd0, 16'h1234, 1'b1);
        send_foot(2'd3, 16'h0000, 1'b1);
        send_foot(2'd1, 16'h0000, 1'b0);
        send_foot(2'd2, 16'hFFFF, 1'b0);
        drain();
        random_setting(0);
        send_foot(2'd2, 16'h0000, 1'b0);
        send_foot(2'd3, 16'h0001, 1'b0);
        send_foot(2'd0, 16'h0001, 1'b1);
        send_foot(2'd1, 16'hFFFF, 1'b1);
        drain();
        items = 0;
        for (int phase = 0; phase < 12; phase++) begin
            random_setting(phase < 3 ? phase : 3);
            for (int n = 0; n < 155; n++) begin
                send_foot(2'($urandom_range(0, 3)),
                          $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 3)) * 16'h5555
                                                    : 16'($urandom),
                          1'($urandom_range(0, 1)));
                items++;
            end
            drain();
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> cycloid_foot_trajectory_top.f
+incdir+src
src/cft_pkg.sv
src/cycloid_foot_trajectory_top.sv
bench/cft_checker.sv
bench/tb.sv
